### hw/rtl/assert_macros.svh
// assertion helpers used by the station table checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion, property given whole
`define SUT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define SUT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    `SUT_ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define SUT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    `SUT_ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

### hw/rtl/sut_pkg.sv
// ----------------------------------------------------------------------------
// sut_pkg
// shared types and constants of the sorted unique station table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sut_pkg;

    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_FREQ_BITS   = 17;
    localparam int OP_W            = 2;
    localparam int STATUS_W        = 2;
    localparam int POS_W           = 5;
    localparam int CNT_OUT_W       = 6;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_FULL     = 2'd2,
        ST_DONE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_WRITE,
        S_READ,
        S_RESP
    } state_t;

    // flags of the registered table read and its compare against the key
    typedef struct packed {
        logic vld;
        logic eq;
        logic gt;
    } rd_flags_t;

endpackage

`default_nettype wire

### hw/rtl/sut_table.sv
// ----------------------------------------------------------------------------
// sut_table
// station table memory with registered read port and shared key comparator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sut_table #(
    parameter int TABLE_DEPTH = sut_pkg::DEF_TABLE_DEPTH,
    parameter int FREQ_BITS   = sut_pkg::DEF_FREQ_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           rd_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    input  wire logic                           wr_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  wire logic [FREQ_BITS-1:0]           wr_data,
    input  wire logic [FREQ_BITS-1:0]           key,
    output logic      [FREQ_BITS-1:0]           rd_data,
    output logic      [$clog2(TABLE_DEPTH)-1:0] rd_idx,
    output sut_pkg::rd_flags_t                  flags
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [FREQ_BITS-1:0] mem [TABLE_DEPTH];
    logic [FREQ_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
        end
    end

    // one comparator, reused by every scan step
    assign flags.vld = rd_vld_reg;
    assign flags.eq  = (rd_data_reg == key);
    assign flags.gt  = (rd_data_reg > key);

    assign rd_data = rd_data_reg;
    assign rd_idx  = rd_idx_reg;

endmodule

`default_nettype wire

### hw/rtl/sorted_unique_insert_table_top.sv
// ----------------------------------------------------------------------------
// sorted_unique_insert_table_top
// sorted table of unique station frequencies with insert, clear and read
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// input     in         in_valid / in_ready  opcode, frequency, read_index
// result    out        out_valid/out_ready  status, position, entry_value,
//                                           entry_count
//
// every input transfer yields exactly one result transfer
// insert: accept, scan up from entry 0 to the first entry not below the key,
//   shift the entries from count-1 down to the hit one up a slot, write, then
//   result; scan and shift share the single table read port, and the longest
//   insert is one that must shift in a table one short of full
// clear and the unused opcode go straight to the result state, read via S_READ
// reset clears the entry count but not the table memory; entries at or above
//   the count are never reported, so the table memory needs no clearing pass
// a result waits in the output register while the next item is accepted; the
//   sequencer holds in its result state until that register is free
//
`timescale 1ns / 1ps
`default_nettype none

module sorted_unique_insert_table_top #(
    parameter int TABLE_DEPTH = sut_pkg::DEF_TABLE_DEPTH,
    parameter int FREQ_BITS   = sut_pkg::DEF_FREQ_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [sut_pkg::OP_W-1:0]      opcode,
    input  wire logic [FREQ_BITS-1:0]          frequency,
    input  wire logic [sut_pkg::POS_W-1:0]     read_index,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [sut_pkg::STATUS_W-1:0]       status,
    output logic [sut_pkg::POS_W-1:0]          position,
    output logic [FREQ_BITS-1:0]               entry_value,
    output logic [sut_pkg::CNT_OUT_W-1:0]      entry_count
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (sut_pkg::POS_W > CNT_W) ? sut_pkg::POS_W : CNT_W;
    localparam int POS_W = sut_pkg::POS_W;

    // sequencer state
    sut_pkg::state_t state_reg, state_next;

    // item and table bookkeeping
    logic [FREQ_BITS-1:0] freq_reg,     freq_next;
    logic [IDX_W-1:0]     pos_reg,      pos_next;
    logic [CNT_W-1:0]     cnt_reg,      cnt_next;
    logic [CNT_W-1:0]     scan_ptr_reg, scan_ptr_next;
    logic [IDX_W-1:0]     sh_ptr_reg,   sh_ptr_next;
    logic                 sh_busy_reg,  sh_busy_next;
    logic [POS_W-1:0]     ridx_reg,     ridx_next;
    logic                 rd_hit_reg,   rd_hit_next;

    // pending result
    sut_pkg::status_t     res_status_reg, res_status_next;
    logic [POS_W-1:0]     res_pos_reg,    res_pos_next;
    logic [FREQ_BITS-1:0] res_value_reg,  res_value_next;

    // output register
    logic                              out_valid_reg,  out_valid_next;
    sut_pkg::status_t                  out_status_reg, out_status_next;
    logic [POS_W-1:0]                  out_pos_reg,    out_pos_next;
    logic [FREQ_BITS-1:0]              out_value_reg,  out_value_next;
    logic [sut_pkg::CNT_OUT_W-1:0]     out_count_reg,  out_count_next;

    // table port
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [FREQ_BITS-1:0] wr_data;
    logic [FREQ_BITS-1:0] rd_data;
    logic [IDX_W-1:0]     rd_idx;
    sut_pkg::rd_flags_t   flags;

    // decode helpers
    sut_pkg::opcode_t op;
    logic             in_fire;
    logic             slot_free;
    logic             table_full;
    logic             scan_more;
    logic             scan_hit;
    logic             scan_end;
    logic             issue_scan;
    logic             issue_shift;

    sut_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FREQ_BITS   (FREQ_BITS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .key     (freq_reg),
        .rd_data (rd_data),
        .rd_idx  (rd_idx),
        .flags   (flags)
    );

    assign op         = sut_pkg::opcode_t'(opcode);
    assign in_ready   = (state_reg == sut_pkg::S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign slot_free  = !out_valid_reg || out_ready;
    assign table_full = (cnt_reg == CNT_W'(TABLE_DEPTH));

    // scan: stop at the first entry not below the key (table is sorted)
    assign scan_more   = (scan_ptr_reg < cnt_reg);
    assign scan_hit    = flags.vld && (flags.eq || flags.gt);
    assign scan_end    = !flags.vld && !scan_more;
    assign issue_scan  = (state_reg == sut_pkg::S_SCAN) && !scan_hit && scan_more;
    assign issue_shift = (state_reg == sut_pkg::S_SHIFT) && sh_busy_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sut_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (op)
                        sut_pkg::OP_INSERT:
                        begin
                            // zero is the empty marker and never goes in
                            state_next = (frequency == '0) ? sut_pkg::S_RESP : sut_pkg::S_SCAN;
                        end
                        sut_pkg::OP_READ:
                        begin
                            state_next = sut_pkg::S_READ;
                        end
                        sut_pkg::OP_CLEAR, sut_pkg::OP_NONE:
                        begin
                            state_next = sut_pkg::S_RESP;
                        end
                    endcase
                end
            end
            sut_pkg::S_SCAN:
            begin
                if (scan_hit)
                begin
                    if (flags.eq || table_full)
                    begin
                        state_next = sut_pkg::S_RESP;
                    end
                    else
                    begin
                        state_next = sut_pkg::S_SHIFT;
                    end
                end
                else if (scan_end)
                begin
                    state_next = table_full ? sut_pkg::S_RESP : sut_pkg::S_WRITE;
                end
            end
            sut_pkg::S_SHIFT:
            begin
                if (flags.vld && (rd_idx == pos_reg))
                begin
                    state_next = sut_pkg::S_WRITE;
                end
            end
            sut_pkg::S_WRITE, sut_pkg::S_READ:
            begin
                state_next = sut_pkg::S_RESP;
            end
            sut_pkg::S_RESP:
            begin
                if (slot_free)
                begin
                    state_next = sut_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sut_pkg::S_IDLE;
            end
        endcase
    end

    // datapath control and register next values
    always_comb
    begin
        freq_next       = freq_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        scan_ptr_next   = scan_ptr_reg;
        sh_ptr_next     = sh_ptr_reg;
        sh_busy_next    = sh_busy_reg;
        ridx_next       = ridx_reg;
        rd_hit_next     = rd_hit_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        rd_en           = 1'b0;
        rd_addr         = scan_ptr_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = freq_reg;

        // result register drains on a transfer
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            sut_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    freq_next       = frequency;
                    scan_ptr_next   = '0;
                    ridx_next       = read_index;
                    rd_hit_next     = (CMP_W'(read_index) < CMP_W'(cnt_reg));
                    res_status_next = sut_pkg::ST_DONE;
                    res_pos_next    = '0;
                    res_value_next  = '0;
                    unique case (op)
                        sut_pkg::OP_INSERT:
                        begin
                            res_status_next = sut_pkg::ST_PRESENT;
                        end
                        sut_pkg::OP_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        sut_pkg::OP_READ:
                        begin
                            rd_en   = 1'b1;
                            rd_addr = IDX_W'(read_index);
                        end
                        sut_pkg::OP_NONE:
                        begin
                            res_status_next = sut_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            sut_pkg::S_SCAN:
            begin
                rd_en   = issue_scan;
                rd_addr = scan_ptr_reg[IDX_W-1:0];
                if (issue_scan)
                begin
                    scan_ptr_next = scan_ptr_reg + CNT_W'(1);
                end
                if (scan_hit)
                begin
                    if (flags.eq)
                    begin
                        res_status_next = sut_pkg::ST_PRESENT;
                        res_pos_next    = POS_W'(rd_idx);
                    end
                    else if (table_full)
                    begin
                        res_status_next = sut_pkg::ST_FULL;
                        res_pos_next    = '0;
                    end
                    else
                    begin
                        // move entries count-1 down to the hit one up a slot
                        pos_next     = rd_idx;
                        sh_ptr_next  = IDX_W'(cnt_reg - CNT_W'(1));
                        sh_busy_next = 1'b1;
                    end
                end
                else if (scan_end)
                begin
                    if (table_full)
                    begin
                        res_status_next = sut_pkg::ST_FULL;
                        res_pos_next    = '0;
                    end
                    else
                    begin
                        pos_next = IDX_W'(cnt_reg);
                    end
                end
            end
            sut_pkg::S_SHIFT:
            begin
                // read one slot below while the previous read is written up
                rd_en   = issue_shift;
                rd_addr = sh_ptr_reg;
                if (issue_shift)
                begin
                    if (sh_ptr_reg == pos_reg)
                    begin
                        sh_busy_next = 1'b0;
                    end
                    else
                    begin
                        sh_ptr_next = sh_ptr_reg - IDX_W'(1);
                    end
                end
                if (flags.vld)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_idx + IDX_W'(1);
                    wr_data = rd_data;
                end
            end
            sut_pkg::S_WRITE:
            begin
                wr_en           = 1'b1;
                wr_addr         = pos_reg;
                wr_data         = freq_reg;
                cnt_next        = cnt_reg + CNT_W'(1);
                res_status_next = sut_pkg::ST_INSERTED;
                res_pos_next    = POS_W'(pos_reg);
                res_value_next  = '0;
            end
            sut_pkg::S_READ:
            begin
                res_status_next = sut_pkg::ST_DONE;
                res_pos_next    = ridx_reg;
                res_value_next  = rd_hit_reg ? rd_data : '0;
            end
            sut_pkg::S_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = res_pos_reg;
                    out_value_next  = res_value_reg;
                    out_count_next  = sut_pkg::CNT_OUT_W'(cnt_reg);
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sut_pkg::S_IDLE;
            cnt_reg       <= '0;
            sh_busy_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sh_busy_reg   <= sh_busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        freq_reg       <= freq_next;
        pos_reg        <= pos_next;
        scan_ptr_reg   <= scan_ptr_next;
        sh_ptr_reg     <= sh_ptr_next;
        ridx_reg       <= ridx_next;
        rd_hit_reg     <= rd_hit_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign position    = out_pos_reg;
    assign entry_value = out_value_reg;
    assign entry_count = out_count_reg;

endmodule

`default_nettype wire

### hw/rtl/sut_checker.sv
// ----------------------------------------------------------------------------
// sut_checker
// port-level checks of the station table, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sut_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [sut_pkg::STATUS_W-1:0]  status,
    input wire logic [sut_pkg::POS_W-1:0]     position
);

    // stalled result holds
    `SUT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(position), "result changed while stalled")

    // sequencer leaves idle on every input transfer
    `SUT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready stayed high after a transfer")

    // a full report carries no position
    `SUT_ASSERT_IMP(a_full_pos_zero, clk, rst_n, out_valid && (status == sut_pkg::ST_FULL), position == '0, "full result with nonzero position")

endmodule

bind sorted_unique_insert_table_top sut_checker u_sut_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .position  (position)
);

`default_nettype wire
